// ===== hdl/primary_ray_direction_defines.svh =====
// ---------------------------------------------------------------------------
// primary_ray_direction assertion macros
// Shared concurrent check wrappers for the ray direction block.
// ---------------------------------------------------------------------------
`ifndef PRIMARY_RAY_DIRECTION_DEFINES_SVH
`define PRIMARY_RAY_DIRECTION_DEFINES_SVH

// same-cycle implication
`define PRD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("primary_ray_direction: check failed");

// next-cycle implication
`define PRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("primary_ray_direction: check failed");

`endif

// ===== hdl/prd_pkg.sv =====
// ---------------------------------------------------------------------------
// prd_pkg
// Types and constants shared by the primary ray direction pipeline.
// ---------------------------------------------------------------------------
package prd_pkg;

   localparam int DIM_W     = 13;
   localparam int OUT_W     = 18;
   localparam int MAG_W     = 31;
   localparam int MSQ_W     = 62;
   localparam int Q_W       = 64;
   localparam int NSTEP     = 17;
   localparam int K_W       = 17;
   localparam int SQ_SHIFT  = 34;
   localparam int E_W       = 102;
   localparam int QT_W      = 82;
   localparam int CSR_IDX_W = 3;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VIEW   = 3'd0,
      CSR_UP     = 3'd1,
      CSR_RIGHT  = 3'd2,
      CSR_WIDTH  = 3'd3,
      CSR_HEIGHT = 3'd4
   } csr_index_type;

   typedef logic [DIM_W-1:0] dim_type;

   typedef struct packed {
      logic                  valid;
      logic                  degenerate;
      logic [2:0]            neg;
      logic [Q_W-1:0]        q;
      logic [2:0][E_W-1:0]   e0;
   } norm_word_type;

   typedef struct packed {
      logic                  valid;
      logic                  degenerate;
      logic [2:0]            neg;
      logic [2:0][K_W-1:0]   k;
   } round_word_type;

endpackage

// ===== hdl/prd_req_if.sv =====
// ---------------------------------------------------------------------------
// prd_req_if
// Sample position channel: valid/ready with pixel coordinates.
// ---------------------------------------------------------------------------
interface prd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_x;
   logic [15:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== hdl/prd_rsp_if.sv =====
// ---------------------------------------------------------------------------
// prd_rsp_if
// Unit direction channel: valid/ready with Q1.16 components and flag.
// ---------------------------------------------------------------------------
interface prd_rsp_if import prd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] dir_x;
   logic signed [OUT_W-1:0] dir_y;
   logic signed [OUT_W-1:0] dir_z;
   logic                    degenerate;

   modport source (output valid, output dir_x, output dir_y, output dir_z,
                   output degenerate, input ready);
   modport sink   (input valid, input dir_x, input dir_y, input dir_z,
                   input degenerate, output ready);
endinterface

// ===== hdl/prd_front.sv =====
// ---------------------------------------------------------------------------
// prd_front
// Four stages: offsets, scale products, component products, vector sum.
// ---------------------------------------------------------------------------
module prd_front
   import prd_pkg::*;
#(
   parameter int SUBPIXEL_BITS = 4,
   parameter int VEC_FRAC_BITS = 16,
   parameter int V_W           = 56
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic [15:0]                  pixel_x,
   input  logic [15:0]                  pixel_y,
   input  logic [3*(VEC_FRAC_BITS+5)-1:0] view_vec,
   input  logic [3*(VEC_FRAC_BITS+5)-1:0] up_vec,
   input  logic [3*(VEC_FRAC_BITS+5)-1:0] right_vec,
   input  dim_type                      width,
   input  dim_type                      height,
   output logic                         out_valid,
   output logic signed [V_W-1:0]        out_v [3]
);

   localparam int CW   = VEC_FRAC_BITS + 5;
   localparam int NX_W = ((17 > DIM_W + SUBPIXEL_BITS) ? 17 : DIM_W + SUBPIXEL_BITS) + 2;
   localparam int SC_W = 2 * DIM_W + SUBPIXEL_BITS;
   localparam int P_W  = NX_W + DIM_W + 1;
   localparam int PV_W = CW + SC_W + 1;
   localparam int PU_W = CW + P_W;

   dim_type w_eff, h_eff;
   assign w_eff = (width  == '0) ? DIM_W'(1) : width;
   assign h_eff = (height == '0) ? DIM_W'(1) : height;

   // stage A: scaled pixel offsets
   logic signed [NX_W-1:0] one, px2, py2, wone, hone;
   logic signed [NX_W-1:0] nx_in, ny_in, nx_ff, ny_ff;
   logic                   a_valid_ff;

   assign one   = NX_W'(1) << SUBPIXEL_BITS;
   assign px2   = NX_W'({pixel_x, 1'b0});
   assign py2   = NX_W'({pixel_y, 1'b0});
   assign wone  = NX_W'(w_eff) << SUBPIXEL_BITS;
   assign hone  = NX_W'(h_eff) << SUBPIXEL_BITS;
   assign nx_in = px2 + one - wone;
   assign ny_in = hone - py2 + one;

   // stage B: scale and cross terms
   logic [2*DIM_W-1:0]    wh;
   logic [SC_W-1:0]       scale_in, scale_ff;
   logic signed [P_W-1:0] nyw_in, nxh_in, nyw_ff, nxh_ff;
   logic                  b_valid_ff;

   assign wh       = w_eff * h_eff;
   assign scale_in = SC_W'(wh) << SUBPIXEL_BITS;
   assign nyw_in   = ny_ff * $signed({1'b0, w_eff});
   assign nxh_in   = nx_ff * $signed({1'b0, h_eff});

   // stage C: component products
   logic signed [PV_W-1:0] pv_in [3];
   logic signed [PV_W-1:0] pv_ff [3];
   logic signed [PU_W-1:0] pu_in [3];
   logic signed [PU_W-1:0] pu_ff [3];
   logic signed [PU_W-1:0] pr_in [3];
   logic signed [PU_W-1:0] pr_ff [3];
   logic                   c_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pv_in[i] = $signed(view_vec[i*CW +: CW]) * $signed({1'b0, scale_ff});
         pu_in[i] = $signed(up_vec[i*CW +: CW]) * nyw_ff;
         pr_in[i] = $signed(right_vec[i*CW +: CW]) * nxh_ff;
      end
   end

   // stage D: sum
   logic signed [V_W-1:0] v_in [3];
   logic signed [V_W-1:0] v_ff [3];
   logic                  d_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v_in[i] = V_W'(pv_ff[i]) + V_W'(pu_ff[i]) + V_W'(pr_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
         scale_ff <= scale_in;
         nyw_ff   <= nyw_in;
         nxh_ff   <= nxh_in;
         for (int i = 0; i < 3; i++) begin
            pv_ff[i] <= pv_in[i];
            pu_ff[i] <= pu_in[i];
            pr_ff[i] <= pr_in[i];
            v_ff[i]  <= v_in[i];
         end
      end
   end

   assign out_valid = d_valid_ff;
   assign out_v     = v_ff;

endmodule

// ===== hdl/prd_norm.sv =====
// ---------------------------------------------------------------------------
// prd_norm
// Six stages: magnitude, range shift, truncation, squares, length, seed.
// ---------------------------------------------------------------------------
module prd_norm
   import prd_pkg::*;
#(
   parameter int V_W = 56
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic signed [V_W-1:0] in_v [3],
   output norm_word_type         out_word
);

   localparam int SH_N = V_W - MAG_W;
   localparam int SH_W = $clog2(SH_N + 1);

   // stage E: sign and magnitude
   logic [V_W-1:0] mag_in [3];
   logic [V_W-1:0] e_mag_ff [3];
   logic [2:0]     neg_in, e_neg_ff;
   logic           e_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = in_v[i][V_W-1];
         mag_in[i] = neg_in[i] ? (~in_v[i] + V_W'(1)) : in_v[i];
      end
   end

   // stage F: common right shift
   logic [V_W-1:0]  orv;
   logic [SH_N-1:0] therm;
   logic [SH_W-1:0] sh_in, f_sh_ff;
   logic [V_W-1:0]  f_mag_ff [3];
   logic [2:0]      f_neg_ff;
   logic            f_degen_ff, f_valid_ff;

   assign orv = e_mag_ff[0] | e_mag_ff[1] | e_mag_ff[2];
   always_comb begin
      for (int p = 0; p < SH_N; p++) begin
         therm[p] = (orv >> (MAG_W + p)) != '0;
      end
   end
   assign sh_in = SH_W'($countones(therm));

   // stage G: truncated magnitudes
   logic [MAG_W-1:0] m_in [3];
   logic [MAG_W-1:0] g_m_ff [3];
   logic [2:0]       g_neg_ff;
   logic             g_degen_ff, g_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m_in[i] = MAG_W'(f_mag_ff[i] >> f_sh_ff);
      end
   end

   // stage H: squares
   logic [MSQ_W-1:0] h_msq_ff [3];
   logic [2:0]       h_neg_ff;
   logic             h_degen_ff, h_valid_ff;

   // stage I: squared length
   logic [Q_W-1:0]   q_in, i_q_ff;
   logic [MSQ_W-1:0] i_msq_ff [3];
   logic [2:0]       i_neg_ff;
   logic             i_degen_ff, i_valid_ff;

   assign q_in = Q_W'(h_msq_ff[0]) + Q_W'(h_msq_ff[1]) + Q_W'(h_msq_ff[2]);

   // stage J: search seed 2^34 m^2 - q
   norm_word_type j_word_in, j_word_ff;

   always_comb begin
      j_word_in.valid      = i_valid_ff;
      j_word_in.degenerate = i_degen_ff;
      j_word_in.neg        = i_neg_ff;
      j_word_in.q          = i_q_ff;
      for (int i = 0; i < 3; i++) begin
         j_word_in.e0[i] = (E_W'(i_msq_ff[i]) << SQ_SHIFT) - E_W'(i_q_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff      <= 1'b0;
         f_valid_ff      <= 1'b0;
         g_valid_ff      <= 1'b0;
         h_valid_ff      <= 1'b0;
         i_valid_ff      <= 1'b0;
         j_word_ff.valid <= 1'b0;
      end else if (advance) begin
         e_valid_ff      <= in_valid;
         f_valid_ff      <= e_valid_ff;
         g_valid_ff      <= f_valid_ff;
         h_valid_ff      <= g_valid_ff;
         i_valid_ff      <= h_valid_ff;
         j_word_ff.valid <= j_word_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_neg_ff   <= neg_in;
         f_neg_ff   <= e_neg_ff;
         f_sh_ff    <= sh_in;
         f_degen_ff <= (orv == '0);
         g_neg_ff   <= f_neg_ff;
         g_degen_ff <= f_degen_ff;
         h_neg_ff   <= g_neg_ff;
         h_degen_ff <= g_degen_ff;
         i_neg_ff   <= h_neg_ff;
         i_degen_ff <= h_degen_ff;
         i_q_ff     <= q_in;
         j_word_ff.degenerate <= j_word_in.degenerate;
         j_word_ff.neg        <= j_word_in.neg;
         j_word_ff.q          <= j_word_in.q;
         j_word_ff.e0         <= j_word_in.e0;
         for (int i = 0; i < 3; i++) begin
            e_mag_ff[i] <= mag_in[i];
            f_mag_ff[i] <= e_mag_ff[i];
            g_m_ff[i]   <= m_in[i];
            h_msq_ff[i] <= g_m_ff[i] * g_m_ff[i];
            i_msq_ff[i] <= h_msq_ff[i];
         end
      end
   end

   assign out_word = j_word_ff;

endmodule

// ===== hdl/prd_round.sv =====
// ---------------------------------------------------------------------------
// prd_round
// Seventeen stages, one result bit each, three lanes: largest k with
// (2k-1)^2 q <= 2^34 m^2, tracked as a running remainder.
// ---------------------------------------------------------------------------
module prd_round
   import prd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  norm_word_type  in_word,
   output round_word_type out_word
);

   logic                 valid_ff [NSTEP];
   logic                 degen_ff [NSTEP];
   logic [2:0]           neg_ff   [NSTEP];
   logic [Q_W-1:0]       q_ff     [NSTEP];
   logic [E_W-1:0]       e_ff     [NSTEP][3];
   logic [QT_W-1:0]      qt_ff    [NSTEP][3];
   logic [K_W-1:0]       k_ff     [NSTEP][3];

   for (genvar g = 0; g < NSTEP; g++) begin : g_step
      localparam int J = NSTEP - 1 - g;

      logic            valid_p, degen_p;
      logic [2:0]      neg_p;
      logic [Q_W-1:0]  q_p;
      logic [E_W-1:0]  e_p  [3];
      logic [QT_W-1:0] qt_p [3];
      logic [K_W-1:0]  k_p  [3];
      logic [E_W-1:0]  qe;
      logic [E_W-1:0]  cand [3];
      logic [2:0]      take;

      if (g == 0) begin : g_head
         always_comb begin
            valid_p = in_word.valid;
            degen_p = in_word.degenerate;
            neg_p   = in_word.neg;
            q_p     = in_word.q;
            for (int i = 0; i < 3; i++) begin
               e_p[i]  = in_word.e0[i];
               qt_p[i] = '0;
               k_p[i]  = '0;
            end
         end
      end else begin : g_body
         always_comb begin
            valid_p = valid_ff[g-1];
            degen_p = degen_ff[g-1];
            neg_p   = neg_ff[g-1];
            q_p     = q_ff[g-1];
            for (int i = 0; i < 3; i++) begin
               e_p[i]  = e_ff[g-1][i];
               qt_p[i] = qt_ff[g-1][i];
               k_p[i]  = k_ff[g-1][i];
            end
         end
      end

      assign qe = E_W'(q_p);

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            cand[i] = e_p[i] - (E_W'(qt_p[i]) << (J + 2)) - (qe << (2*J + 2))
                      + (qe << (J + 2));
            take[i] = ~cand[i][E_W-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (advance) begin
            valid_ff[g] <= valid_p;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            degen_ff[g] <= degen_p;
            neg_ff[g]   <= neg_p;
            q_ff[g]     <= q_p;
            for (int i = 0; i < 3; i++) begin
               e_ff[g][i]  <= take[i] ? cand[i] : e_p[i];
               qt_ff[g][i] <= take[i] ? (qt_p[i] + (QT_W'(q_p) << (J + 1))) : qt_p[i];
               k_ff[g][i]  <= k_p[i] | (take[i] ? (K_W'(1) << J) : '0);
            end
         end
      end
   end

   always_comb begin
      out_word.valid      = valid_ff[NSTEP-1];
      out_word.degenerate = degen_ff[NSTEP-1];
      out_word.neg        = neg_ff[NSTEP-1];
      for (int i = 0; i < 3; i++) begin
         out_word.k[i] = k_ff[NSTEP-1][i];
      end
   end

endmodule

// ===== hdl/primary_ray_direction.sv =====
// Depth is set by the 17-stage rounding search in prd_round.
// Throughput: one word per cycle while the output is not stalled.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears all valid bits and loads the register defaults
// (vectors zero, width 640, height 480).
// ---------------------------------------------------------------------------
// primary_ray_direction
// Pinhole camera primary ray generator: pixel sample to unit Q1.16 vector.
// ---------------------------------------------------------------------------
`include "primary_ray_direction_defines.svh"

module primary_ray_direction
   import prd_pkg::*;
#(
   parameter int SUBPIXEL_BITS = 4,
   parameter int VEC_FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   prd_req_if.sink                          req_chan,
   prd_rsp_if.source                        rsp_chan,
   input  logic                             csr_wen,
   input  logic [CSR_IDX_W-1:0]             csr_index,
   input  logic [3*(VEC_FRAC_BITS+5)-1:0]   csr_wdata
);

   localparam int CW   = VEC_FRAC_BITS + 5;
   localparam int NX_W = ((17 > DIM_W + SUBPIXEL_BITS) ? 17 : DIM_W + SUBPIXEL_BITS) + 2;
   localparam int SC_W = 2 * DIM_W + SUBPIXEL_BITS;
   localparam int P_W  = NX_W + DIM_W + 1;
   localparam int PV_W = CW + SC_W + 1;
   localparam int PU_W = CW + P_W;
   localparam int V_W  = ((PV_W > PU_W) ? PV_W : PU_W) + 2;

   logic [3*CW-1:0] view_ff, up_ff, right_ff;
   dim_type         width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff   <= '0;
         up_ff     <= '0;
         right_ff  <= '0;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_VIEW:   view_ff   <= csr_wdata;
            CSR_UP:     up_ff     <= csr_wdata;
            CSR_RIGHT:  right_ff  <= csr_wdata;
            CSR_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   logic advance;
   logic out_valid_ff;

   assign advance        = ~out_valid_ff | rsp_chan.ready;
   assign req_chan.ready = advance;

   logic                  sum_valid;
   logic signed [V_W-1:0] sum_v [3];
   norm_word_type         norm_word;
   round_word_type        rnd_word;

   prd_front #(
      .SUBPIXEL_BITS (SUBPIXEL_BITS),
      .VEC_FRAC_BITS (VEC_FRAC_BITS),
      .V_W           (V_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_chan.valid),
      .pixel_x   (req_chan.pixel_x),
      .pixel_y   (req_chan.pixel_y),
      .view_vec  (view_ff),
      .up_vec    (up_ff),
      .right_vec (right_ff),
      .width     (width_ff),
      .height    (height_ff),
      .out_valid (sum_valid),
      .out_v     (sum_v)
   );

   prd_norm #(
      .V_W (V_W)
   ) u_norm (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (sum_valid),
      .in_v     (sum_v),
      .out_word (norm_word)
   );

   prd_round u_round (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_word  (norm_word),
      .out_word (rnd_word)
   );

   logic signed [OUT_W-1:0] dir_in [3];
   logic signed [OUT_W-1:0] dir_ff [3];
   logic                    degen_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (rnd_word.degenerate) begin
            dir_in[i] = '0;
         end else if (rnd_word.neg[i]) begin
            dir_in[i] = -OUT_W'(rnd_word.k[i]);
         end else begin
            dir_in[i] = OUT_W'(rnd_word.k[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= rnd_word.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dir_ff   <= dir_in;
         degen_ff <= rnd_word.degenerate;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.dir_x      = dir_ff[0];
   assign rsp_chan.dir_y      = dir_ff[1];
   assign rsp_chan.dir_z      = dir_ff[2];
   assign rsp_chan.degenerate = degen_ff;

   `PRD_ASSERT_IMPLIES(a_degen_zero, clock, reset, out_valid_ff && degen_ff, dir_ff[0] == '0 && dir_ff[1] == '0 && dir_ff[2] == '0)
   `PRD_ASSERT_IMPLIES(a_unit_range, clock, reset, out_valid_ff, dir_ff[0] <= 18'sd65536 && dir_ff[0] >= -18'sd65536 && dir_ff[1] <= 18'sd65536 && dir_ff[1] >= -18'sd65536 && dir_ff[2] <= 18'sd65536 && dir_ff[2] >= -18'sd65536)
   `PRD_ASSERT_IMPLIES(a_major_axis, clock, reset, out_valid_ff && !degen_ff, dir_ff[0] > 18'sd32768 || dir_ff[0] < -18'sd32768 || dir_ff[1] > 18'sd32768 || dir_ff[1] < -18'sd32768 || dir_ff[2] > 18'sd32768 || dir_ff[2] < -18'sd32768)
   `PRD_ASSERT_NEXT(a_stall_hold, clock, reset, !advance && !reset, $stable(rnd_word))

endmodule

// ===== verif/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for primary_ray_direction: camera setups and pixel
// samples go in, unit directions come out and are checked against an exact
// integer model of the normalization, with random stalls on both channels.
// ---------------------------------------------------------------------------
module tb;
   import prd_pkg::*;

   typedef struct packed {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic signed [OUT_W-1:0] z;
      logic                    degen;
   } dir_word_type;

   typedef struct packed {
      logic [62:0] view;
      logic [62:0] up;
      logic [62:0] right;
      logic [12:0] width;
      logic [12:0] height;
   } camera_type;

   typedef struct packed {
      int           phase;
      logic [15:0]  px;
      logic [15:0]  py;
      bit           typed;
      dir_word_type want;
   } sample_row_type;

   localparam int          NUM_RANDOM_PHASES = 9;
   localparam int          WORDS_PER_PHASE   = 55;
   localparam logic [62:0] ONE_Z  = 63'(65536) << 42;
   localparam logic [62:0] NEG_Z  = 63'(21'h1F0000) << 42;
   localparam logic [62:0] ONE_Y  = 63'(65536) << 21;
   localparam logic [62:0] ONE_X  = 63'(65536);
   localparam logic [62:0] MIN_V  = {21'h100000, 21'h100000, 21'h100000};
   localparam dir_word_type DEGEN = '{x: '0, y: '0, z: '0, degen: 1'b1};
   localparam dir_word_type FWD   = '{x: '0, y: '0, z: 18'sd65536, degen: 1'b0};

   localparam camera_type DIR_CAMS [5] = '{
      '{view: '0,    up: '0,    right: '0,    width: WIDTH_RESET, height: HEIGHT_RESET},
      '{view: ONE_Z, up: '0,    right: '0,    width: 13'd640,     height: 13'd480},
      '{view: NEG_Z, up: ONE_Y, right: ONE_X, width: 13'd640,     height: 13'd480},
      '{view: '0,    up: '0,    right: ONE_X, width: 13'd0,       height: 13'd0},
      '{view: MIN_V, up: MIN_V, right: MIN_V, width: 13'd8191,    height: 13'd8191}
   };

   localparam sample_row_type DIR_ROWS [17] = '{
      '{0, 16'd0,     16'd0,     1'b1, DEGEN},
      '{0, 16'd65535, 16'd65535, 1'b1, DEGEN},
      '{0, 16'd5112,  16'd3848,  1'b1, DEGEN},
      '{1, 16'd0,     16'd65535, 1'b1, FWD},
      '{1, 16'd65535, 16'd0,     1'b1, FWD},
      '{1, 16'd10,    16'd20,    1'b1, FWD},
      '{2, 16'd5112,  16'd3848,  1'b0, DEGEN},
      '{2, 16'd0,     16'd0,     1'b0, DEGEN},
      '{2, 16'd65535, 16'd65535, 1'b0, DEGEN},
      '{2, 16'd10239, 16'd7679,  1'b0, DEGEN},
      '{2, 16'hAAAA,  16'h5555,  1'b0, DEGEN},
      '{3, 16'd0,     16'd0,     1'b1, DEGEN},
      '{3, 16'd65535, 16'd12,    1'b0, DEGEN},
      '{3, 16'd1,     16'd65535, 1'b0, DEGEN},
      '{4, 16'd0,     16'd0,     1'b0, DEGEN},
      '{4, 16'd65535, 16'd65535, 1'b0, DEGEN},
      '{4, 16'd65520, 16'd131,   1'b0, DEGEN}
   };

   logic clock;
   logic reset;
   logic                 csr_wen;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [62:0]          csr_wdata;

   prd_req_if req_if ();
   prd_rsp_if rsp_if ();

   primary_ray_direction dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if.sink),
      .rsp_chan  (rsp_if.source),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   camera_type   cam;
   dir_word_type dir_q [$];
   int           mismatches;
   bit           stalls_on;
   int           ready_hold;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("FAIL primary_ray_direction");
      $finish;
   end

   function automatic longint vec_comp(logic [62:0] r, int i);
      logic signed [20:0] c;
      c = r[i*21 +: 21];
      return longint'(c);
   endfunction

   function automatic dir_word_type unit_direction(logic [15:0] px, logic [15:0] py);
      longint          w, h, nx, ny, sc, v;
      longint unsigned mag [3];
      longint unsigned maxm, q, lo, hi, mid, t;
      bit              neg [3];
      logic [127:0]    rhs, lhs;
      logic [OUT_W-1:0] k [3];
      dir_word_type    d;
      w = (cam.width == 0) ? 1 : longint'(cam.width);
      h = (cam.height == 0) ? 1 : longint'(cam.height);
      nx = 2 * longint'(px) + 16 - w * 16;
      ny = h * 16 - 2 * longint'(py) + 16;
      sc = w * h * 16;
      maxm = 0;
      for (int i = 0; i < 3; i++) begin
         v = vec_comp(cam.view, i) * sc + vec_comp(cam.up, i) * ny * w
           + vec_comp(cam.right, i) * nx * h;
         neg[i] = v < 0;
         mag[i] = neg[i] ? longint'(-v) : longint'(v);
         if (mag[i] > maxm) maxm = mag[i];
      end
      if (maxm == 0) return DEGEN;
      while (maxm >= 64'h8000_0000) begin
         maxm >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      q = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      for (int i = 0; i < 3; i++) begin
         rhs = 128'(mag[i] * mag[i]) << 34;
         lo = 0;
         hi = 65536;
         while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            t = 2 * mid - 1;
            lhs = 128'(t * t) * 128'(q);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
         end
         k[i] = neg[i] ? -OUT_W'(lo) : OUT_W'(lo);
      end
      d.x = k[0];
      d.y = k[1];
      d.z = k[2];
      d.degen = 1'b0;
      return d;
   endfunction

   task automatic write_csr(csr_index_type idx, logic [62:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_camera(camera_type c);
      write_csr(CSR_VIEW, c.view);
      write_csr(CSR_UP, c.up);
      write_csr(CSR_RIGHT, c.right);
      write_csr(CSR_WIDTH, 63'(c.width));
      write_csr(CSR_HEIGHT, 63'(c.height));
      csr_wen <= 1'b0;
      cam = c;
   endtask

   task automatic drain;
      while (dir_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_sample(logic [15:0] px, logic [15:0] py, bit typed,
                              dir_word_type want);
      if (stalls_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.pixel_x <= px;
      req_if.pixel_y <= py;
      do @(posedge clock); while (!req_if.ready);
      dir_q.push_back(typed ? want : unit_direction(px, py));
   endtask

   function automatic logic [20:0] rand_comp();
      case ($urandom_range(0, 4))
         0: return 21'd0;
         1: return 21'h100000;
         2: return 21'h0FFFFF;
         3: return 21'($signed($urandom_range(0, 262143)) - 131072);
         default: return 21'($urandom);
      endcase
   endfunction

   function automatic logic [12:0] rand_dim();
      case ($urandom_range(0, 5))
         0: return 13'd0;
         1: return 13'd1;
         2: return 13'd4096;
         3: return 13'd8191;
         4: return 13'($urandom);
         default: return 13'($urandom_range(1, 64));
      endcase
   endfunction

   always @(posedge clock) begin
      if (stalls_on && ready_hold == 0 && $urandom_range(0, 3) == 0)
         ready_hold = $urandom_range(1, 5);
      rsp_if.ready <= (ready_hold == 0);
      if (ready_hold > 0) ready_hold--;
   end

   always @(posedge clock) begin
      dir_word_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{x: rsp_if.dir_x, y: rsp_if.dir_y, z: rsp_if.dir_z,
                 degen: rsp_if.degenerate};
         if (dir_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp word %p", got);
         end else begin
            want = dir_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("rsp mismatch: exp %p got %p", want, got);
            end
         end
      end
   end

   initial begin
      camera_type  c;
      logic [15:0] px, py;
      int          phase;
      mismatches   = 0;
      stalls_on    = 1'b1;
      ready_hold   = 0;
      reset        = 1'b1;
      csr_wen      = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_if.valid = 1'b0;
      req_if.pixel_x = '0;
      req_if.pixel_y = '0;
      rsp_if.ready = 1'b0;
      cam = DIR_CAMS[0];
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      phase = 0;
      foreach (DIR_ROWS[i]) begin
         if (DIR_ROWS[i].phase != phase) begin
            req_if.valid <= 1'b0;
            drain();
            phase = DIR_ROWS[i].phase;
            load_camera(DIR_CAMS[phase]);
         end
         send_sample(DIR_ROWS[i].px, DIR_ROWS[i].py, DIR_ROWS[i].typed, DEGEN);
         if (DIR_ROWS[i].typed) dir_q[$] = DIR_ROWS[i].want;
      end

      for (int p = 0; p < NUM_RANDOM_PHASES; p++) begin
         req_if.valid <= 1'b0;
         drain();
         if (p == NUM_RANDOM_PHASES - 1) stalls_on = 1'b0;
         c.view   = {rand_comp(), rand_comp(), rand_comp()};
         c.up     = {rand_comp(), rand_comp(), rand_comp()};
         c.right  = {rand_comp(), rand_comp(), rand_comp()};
         c.width  = rand_dim();
         c.height = rand_dim();
         if ($urandom_range(0, 3) == 0) begin
            c.view  = 63'({$urandom, $urandom});
            c.up    = 63'({$urandom, $urandom});
            c.right = 63'({$urandom, $urandom});
         end
         load_camera(c);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if ($urandom_range(0, 3) != 0) begin
               // mostly on-screen samples
               px = 16'($urandom_range(0, ((c.width == 0 ? 1 : c.width) << 4) - 1));
               py = 16'($urandom_range(0, ((c.height == 0 ? 1 : c.height) << 4) - 1));
            end else begin
               px = 16'($urandom);
               py = 16'($urandom);
            end
            send_sample(px, py, 1'b0, DEGEN);
         end
      end

      req_if.valid <= 1'b0;
      drain();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && dir_q.size() == 0)
         $display("PASS primary_ray_direction");
      else
         $display("FAIL primary_ray_direction");
      $finish;
   end

endmodule
